FILE: hw/rtl/can_fragment_reassembler_top_macros.svh
// ----------------------------------------------------------------------------
// CAN fragment reassembler assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CAN_FRAGMENT_REASSEMBLER_TOP_MACROS_SVH
`define CAN_FRAGMENT_REASSEMBLER_TOP_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define CFR_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequence that must hold in the same cycle as the antecedent.
`define CFR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define CFR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/cfr_pkg.sv
// ----------------------------------------------------------------------------
// CAN fragment reassembler package
// Shared types, codes and constants for the reassembler modules.
// ----------------------------------------------------------------------------
package cfr_pkg;

  localparam int unsigned FRAME_BYTES = 8;
  localparam logic [3:0]  FRAME_BYTES_CNT = 4'd8;

  // Addressing modes (ds*4 + gr*2 + di) that carry a trailing peer address.
  localparam logic [2:0] ADDR_MODE_DS_DI    = 3'd5;
  localparam logic [2:0] ADDR_MODE_DS_GR_DI = 3'd7;

  typedef enum logic [1:0] {
    FRAG_SINGLE = 2'd0,
    FRAG_FIRST  = 2'd1,
    FRAG_MIDDLE = 2'd2,
    FRAG_LAST   = 2'd3
  } frag_type_t;

  typedef enum logic [2:0] {
    ST_FIRST        = 3'd0,
    ST_MIDDLE       = 3'd1,
    ST_COMPLETE     = 3'd2,
    ST_SEQ_ERROR    = 3'd3,
    ST_UNFRAGMENTED = 3'd4,
    ST_OVERFLOW     = 3'd5
  } status_t;

  typedef struct packed {
    logic [1:0]  fragment_type;
    logic [2:0]  frame_counter;
    logic        dest_select;
    logic        group_flag;
    logic        direct_flag;
    logic [1:0]  header_skip;
    logic [3:0]  frame_length;
    logic [63:0] frame_bytes;
  } frame_t;

  typedef struct packed {
    status_t     status;
    logic [63:0] payload_bytes;
    logic [3:0]  payload_count;
    logic [7:0]  total_length;
  } result_t;

  typedef struct packed {
    logic [2:0] expected_counter;
    logic [7:0] message_length;
  } msg_state_t;

endpackage

FILE: hw/rtl/cfr_in_if.sv
// ----------------------------------------------------------------------------
// CAN fragment reassembler frame channel
// Valid/ready channel that carries one received CAN frame per word.
// ----------------------------------------------------------------------------
interface cfr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  fragment_type;
  logic [2:0]  frame_counter;
  logic        dest_select;
  logic        group_flag;
  logic        direct_flag;
  logic [1:0]  header_skip;
  logic [3:0]  frame_length;
  logic [63:0] frame_bytes;

  modport source (
    output valid, fragment_type, frame_counter, dest_select, group_flag,
           direct_flag, header_skip, frame_length, frame_bytes,
    input  ready
  );

  modport sink (
    input  valid, fragment_type, frame_counter, dest_select, group_flag,
           direct_flag, header_skip, frame_length, frame_bytes,
    output ready
  );
endinterface

FILE: hw/rtl/cfr_out_if.sv
// ----------------------------------------------------------------------------
// CAN fragment reassembler result channel
// Valid/ready channel that carries one reassembly result per word.
// ----------------------------------------------------------------------------
interface cfr_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [63:0] payload_bytes;
  logic [3:0]  payload_count;
  logic [7:0]  total_length;

  modport source (
    output valid, status, payload_bytes, payload_count, total_length,
    input  ready
  );

  modport sink (
    input  valid, status, payload_bytes, payload_count, total_length,
    output ready
  );
endinterface

FILE: hw/rtl/cfr_frame_step.sv
// ----------------------------------------------------------------------------
// CAN fragment reassembler frame step
// Combinational byte extraction, counter check and length update for a frame.
// ----------------------------------------------------------------------------
module cfr_frame_step #(
  parameter int unsigned MAX_MESSAGE_BYTES = 255
) (
  input  cfr_pkg::frame_t     frame,
  input  cfr_pkg::msg_state_t state,
  output cfr_pkg::result_t    res,
  output cfr_pkg::msg_state_t state_next
);

  localparam logic [8:0] MaxLen = 9'(MAX_MESSAGE_BYTES);

  logic [2:0]  mode;
  logic        addr_byte;
  logic [3:0]  dlc;
  logic [3:0]  count;
  logic [63:0] shifted;
  logic [63:0] keep_mask;
  logic [2:0]  counter_inc;
  logic [8:0]  sum;

  always_comb begin
    mode      = {frame.dest_select, frame.group_flag, frame.direct_flag};
    addr_byte = (mode == cfr_pkg::ADDR_MODE_DS_DI) || (mode == cfr_pkg::ADDR_MODE_DS_GR_DI);
    dlc       = (frame.frame_length > cfr_pkg::FRAME_BYTES_CNT) ?
                cfr_pkg::FRAME_BYTES_CNT : frame.frame_length;
    counter_inc = state.expected_counter + 3'd1;

    // Byte count by fragment kind; a first fragment also drops header bytes.
    case (cfr_pkg::frag_type_t'(frame.fragment_type))
      cfr_pkg::FRAG_FIRST: begin
        count = cfr_pkg::FRAME_BYTES_CNT - {2'b00, frame.header_skip} - {3'b000, addr_byte};
      end
      cfr_pkg::FRAG_MIDDLE: begin
        count = cfr_pkg::FRAME_BYTES_CNT - {3'b000, addr_byte};
      end
      cfr_pkg::FRAG_LAST: begin
        count = (dlc >= {3'b000, addr_byte}) ? dlc - {3'b000, addr_byte} : 4'd0;
      end
      default: begin
        count = 4'd0;
      end
    endcase

    shifted = (cfr_pkg::frag_type_t'(frame.fragment_type) == cfr_pkg::FRAG_FIRST) ?
              frame.frame_bytes >> {frame.header_skip, 3'b000} : frame.frame_bytes;
    for (int i = 0; i < cfr_pkg::FRAME_BYTES; i++) begin
      keep_mask[i*8 +: 8] = (4'(i) < count) ? 8'hff : 8'h00;
    end

    sum = {1'b0, state.message_length} + {5'b00000, count};

    res.status        = cfr_pkg::ST_UNFRAGMENTED;
    res.payload_bytes = '0;
    res.payload_count = 4'd0;
    state_next        = state;

    case (cfr_pkg::frag_type_t'(frame.fragment_type))
      cfr_pkg::FRAG_FIRST: begin
        res.status                  = cfr_pkg::ST_FIRST;
        res.payload_bytes           = shifted & keep_mask;
        res.payload_count           = count;
        state_next.expected_counter = 3'd0;
        state_next.message_length   = {4'b0000, count};
      end
      cfr_pkg::FRAG_MIDDLE, cfr_pkg::FRAG_LAST: begin
        // The expected counter advances even when the frame is rejected.
        state_next.expected_counter = counter_inc;
        if (counter_inc == frame.frame_counter) begin
          res.payload_bytes = shifted & keep_mask;
          res.payload_count = count;
          if (sum > MaxLen) begin
            res.status                = cfr_pkg::ST_OVERFLOW;
            state_next.message_length = MaxLen[7:0];
          end else begin
            res.status = (cfr_pkg::frag_type_t'(frame.fragment_type) == cfr_pkg::FRAG_MIDDLE) ?
                         cfr_pkg::ST_MIDDLE : cfr_pkg::ST_COMPLETE;
            state_next.message_length = sum[7:0];
          end
        end else begin
          res.status = cfr_pkg::ST_SEQ_ERROR;
        end
      end
      default: begin
        res.status = cfr_pkg::ST_UNFRAGMENTED;
      end
    endcase

    res.total_length = state_next.message_length;
  end

endmodule

FILE: hw/rtl/can_fragment_reassembler_top.sv
// ----------------------------------------------------------------------------
// CAN fragment reassembler top level
// Each accepted frame word yields one registered result word.
// Throughput: one frame per cycle when result.ready; single result register.
// Reset (synchronous rst): counter, length and result valid clear to zero.
// ----------------------------------------------------------------------------
`include "can_fragment_reassembler_top_macros.svh"

// Each accepted frame is decoded in one pass of combinational logic: the
// addressing mode decides whether the last data byte is a peer address, the
// fragment type selects how many bytes to keep, and middle and last fragments
// are checked against the expected counter. The result lands in a single
// output register, and the message state (expected counter and running
// length) is updated at the same edge, so the next frame sees it at once.
//
// The frame side is ready whenever the result register is empty or its word
// is being taken in this cycle, so a waiting result blocks no intake beyond
// the one register; with result ready, one word moves per cycle.
module can_fragment_reassembler_top #(
  parameter int unsigned MAX_MESSAGE_BYTES = 255
) (
  input logic      clk,
  input logic      rst,
  cfr_in_if.sink   frame,
  cfr_out_if.source result
);

  // Message state carried from frame to frame.
  logic [2:0] expected_counter;
  logic [7:0] message_length;

  // Result register.
  logic             out_valid;
  cfr_pkg::result_t out_word;

  cfr_pkg::frame_t     frame_word;
  cfr_pkg::msg_state_t state_cur;
  cfr_pkg::msg_state_t state_next;
  cfr_pkg::result_t    res_next;
  logic                frame_take;

  assign frame_word.fragment_type = frame.fragment_type;
  assign frame_word.frame_counter = frame.frame_counter;
  assign frame_word.dest_select   = frame.dest_select;
  assign frame_word.group_flag    = frame.group_flag;
  assign frame_word.direct_flag   = frame.direct_flag;
  assign frame_word.header_skip   = frame.header_skip;
  assign frame_word.frame_length  = frame.frame_length;
  assign frame_word.frame_bytes   = frame.frame_bytes;

  assign state_cur.expected_counter = expected_counter;
  assign state_cur.message_length   = message_length;

  cfr_frame_step #(
    .MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
  ) u_step (
    .frame      (frame_word),
    .state      (state_cur),
    .res        (res_next),
    .state_next (state_next)
  );

  // The register can take a new word when empty or when its word leaves now.
  assign frame.ready = !out_valid || result.ready;
  assign frame_take  = frame.valid && frame.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_counter <= 3'd0;
      message_length   <= 8'd0;
      out_valid        <= 1'b0;
    end else begin
      if (frame_take) begin
        expected_counter <= state_next.expected_counter;
        message_length   <= state_next.message_length;
        out_valid        <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload of the result register needs no reset; valid guards it.
  always_ff @(posedge clk) begin
    if (frame_take) begin
      out_word <= res_next;
    end
  end

  assign result.valid         = out_valid;
  assign result.status        = out_word.status;
  assign result.payload_bytes = out_word.payload_bytes;
  assign result.payload_count = out_word.payload_count;
  assign result.total_length  = out_word.total_length;

  // A rejected fragment never carries payload.
  `CFR_ASSERT_SAME(a_seq_err_empty, out_valid && (out_word.status == cfr_pkg::ST_SEQ_ERROR), (out_word.payload_count == 4'd0) && (out_word.payload_bytes == 64'd0), "sequence error with payload")

  // The running length never passes the configured limit.
  `CFR_ASSERT_ALWAYS(a_len_limit, {24'd0, message_length} <= 32'(MAX_MESSAGE_BYTES), "message length above limit")

  // A first fragment restarts the counter and reports the new length.
  `CFR_ASSERT_NEXT(a_first_restart, frame_take && (frame.fragment_type == cfr_pkg::FRAG_FIRST), (expected_counter == 3'd0) && (out_word.total_length == message_length), "first fragment did not restart")

  // The reported length matches the stored length right after acceptance.
  `CFR_ASSERT_NEXT(a_len_match, frame_take, out_valid && (out_word.total_length == message_length), "reported length differs from state")

endmodule
